[rtl/amf0_pkg.sv]
// Shared constants for the AMF0 value skip parser: marker codes, result
// status codes and stream widths. No dependencies.
`default_nettype none

package amf0_pkg;

    localparam int MAX_DEPTH_DEF = 16;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    // AMF0 marker bytes
    localparam logic [7:0] MK_NUMBER    = 8'h00;
    localparam logic [7:0] MK_BOOLEAN   = 8'h01;
    localparam logic [7:0] MK_STRING    = 8'h02;
    localparam logic [7:0] MK_OBJECT    = 8'h03;
    localparam logic [7:0] MK_NULL      = 8'h05;
    localparam logic [7:0] MK_UNDEF     = 8'h06;
    localparam logic [7:0] MK_ECMA      = 8'h08;
    localparam logic [7:0] MK_OBJ_END   = 8'h09;
    localparam logic [7:0] MK_STRICT    = 8'h0A;
    localparam logic [7:0] MK_DATE      = 8'h0B;
    localparam logic [7:0] MK_LONG_STR  = 8'h0C;

    localparam logic [31:0] DATE_BYTES  = 32'd10;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MK    = 3'd1;
    localparam logic [2:0] ST_BAD_END   = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_DEEP      = 3'd4;

endpackage

`default_nettype wire

[rtl/amf0_value_skip_parser_top.sv]
// AMF0 value skip parser, top level and only module.
// Depends on amf0_pkg for marker codes, status codes and widths.
`default_nettype none

// Checks the structure of top-level AMF0 values in a byte stream, one byte
// per request on the slave side, tlast on the final byte of a buffer. One
// result request is given per finished top-level value (status ok) or per
// error (bad marker, bad object end, truncated, too deep); after an error
// that is not on the last byte, bytes are dropped up to and including the
// next tlast. Container frames live in a MAX_DEPTH-entry stack memory with a
// registered read. Rate: one byte per cycle, except after a byte that
// completes a value: a top-level value then passes through the read state
// (S_RD), and each container frame inspected otherwise through a stack
// read (S_RD), then evaluate (S_EVAL), so a cascade of strict-array pops
// repeats read and evaluate per frame. The byte path also waits while an
// earlier result has not been taken.
module amf0_value_skip_parser_top #(
    parameter int MAX_DEPTH = amf0_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [amf0_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                           s_tlast,   // last
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [amf0_pkg::M_TDATA_W-1:0]      m_tdata    // [2:0] status,
                                                           // [10:3] marker,
                                                           // [42:11] value_length
);
    import amf0_pkg::*;

    localparam int AW = $clog2(MAX_DEPTH);
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    typedef enum logic [2:0] {
        PH_MARKER, PH_BODY, PH_STRLEN, PH_ECMACNT,
        PH_ARRCNT, PH_KEYLEN, PH_KEYBODY, PH_OBJEND
    } phase_t;

    // accept a byte / read stack top / evaluate stack top
    typedef enum logic [1:0] {S_ACCEPT, S_RD, S_EVAL} seq_t;

    // frame stack: bit 32 strict array, bits 31..0 elements left
    logic [32:0]   frame_mem [MAX_DEPTH];
    logic [32:0]   rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [32:0]   mem_wdata;

    seq_t          state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [31:0]   fc_reg, fc_next;
    logic [31:0]   acc_reg, acc_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [7:0]    top_marker_reg, top_marker_next;
    logic [31:0]   total_reg, total_next;
    logic          disc_reg, disc_next;
    logic          last_reg, last_next;
    logic          m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic          out_free, accept, step_last, st_valid, end_step;
    logic [2:0]    st_code;
    logic [7:0]    b;
    logic [31:0]   acc_shift, base_total, cnt;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_ACCEPT) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign b         = s_tdata[7:0];
    assign acc_shift = {acc_reg[23:0], b};
    assign step_last = (state_reg == S_ACCEPT) ? s_tlast : last_reg;
    assign cnt       = rdata_reg[31:0] - 32'd1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        fc_next         = fc_reg;
        acc_next        = acc_reg;
        depth_next      = depth_reg;
        top_marker_next = top_marker_reg;
        total_next      = total_reg;
        disc_next       = disc_reg;
        last_next       = last_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = depth_reg[AW-1:0];
        mem_raddr       = depth_reg[AW-1:0] - AW'(1);
        mem_wdata       = '0;
        st_valid        = 1'b0;
        st_code         = ST_OK;
        end_step        = 1'b0;
        base_total      = total_reg;

        unique case (state_reg)
            S_ACCEPT: begin
                if (accept && disc_reg) begin
                    if (s_tlast) begin
                        disc_next  = 1'b0;
                        phase_next = PH_MARKER;
                        fc_next    = '0;
                        acc_next   = '0;
                        depth_next = '0;
                    end
                end else if (accept) begin
                    if (phase_reg == PH_MARKER && depth_reg == '0) begin
                        top_marker_next = b;
                        base_total      = '0;
                    end
                    total_next = (base_total == 32'hFFFF_FFFF) ? base_total
                                                                : base_total + 32'd1;
                    last_next  = s_tlast;
                    end_step   = 1'b1;
                    unique case (phase_reg)
                        PH_MARKER: begin
                            unique case (b)
                                MK_NUMBER: begin
                                    phase_next = PH_BODY;
                                    fc_next    = 32'd8;
                                end
                                MK_BOOLEAN: begin
                                    phase_next = PH_BODY;
                                    fc_next    = 32'd1;
                                end
                                MK_DATE: begin
                                    phase_next = PH_BODY;
                                    fc_next    = DATE_BYTES;
                                end
                                MK_STRING, MK_LONG_STR: begin
                                    phase_next = PH_STRLEN;
                                    fc_next    = (b == MK_STRING) ? 32'd2 : 32'd4;
                                    acc_next   = '0;
                                end
                                MK_NULL, MK_UNDEF: begin
                                    end_step   = 1'b0;
                                    state_next = S_RD;
                                end
                                MK_OBJECT, MK_ECMA, MK_STRICT: begin
                                    if (depth_reg >= DEPTH_MAX) begin
                                        st_valid = 1'b1;
                                        st_code  = ST_DEEP;
                                    end else begin
                                        mem_we     = 1'b1;
                                        mem_wdata  = {(b == MK_STRICT), 32'd0};
                                        depth_next = depth_reg + DW'(1);
                                        fc_next    = (b == MK_OBJECT) ? 32'd2 : 32'd4;
                                        acc_next   = '0;
                                        phase_next = (b == MK_OBJECT) ? PH_KEYLEN :
                                                     (b == MK_ECMA)   ? PH_ECMACNT :
                                                                        PH_ARRCNT;
                                    end
                                end
                                default: begin
                                    st_valid = 1'b1;
                                    st_code  = ST_BAD_MK;
                                end
                            endcase
                        end
                        PH_BODY: begin
                            fc_next = fc_reg - 32'd1;
                            if (fc_next == '0) begin
                                end_step   = 1'b0;
                                state_next = S_RD;
                            end
                        end
                        PH_KEYBODY: begin
                            fc_next = fc_reg - 32'd1;
                            if (fc_next == '0) phase_next = PH_MARKER;
                        end
                        PH_ECMACNT: begin
                            fc_next = fc_reg - 32'd1;
                            if (fc_next == '0) begin
                                phase_next = PH_KEYLEN;
                                fc_next    = 32'd2;
                                acc_next   = '0;
                            end
                        end
                        PH_STRLEN, PH_ARRCNT, PH_KEYLEN: begin
                            acc_next = acc_shift;
                            fc_next  = fc_reg - 32'd1;
                            if (fc_next == '0) begin
                                priority case (phase_reg)
                                    PH_STRLEN: begin
                                        if (acc_shift == '0) begin
                                            end_step   = 1'b0;
                                            state_next = S_RD;
                                        end else begin
                                            phase_next = PH_BODY;
                                            fc_next    = acc_shift;
                                        end
                                    end
                                    PH_KEYLEN: begin
                                        if (acc_shift == '0) begin
                                            phase_next = PH_OBJEND;
                                        end else begin
                                            phase_next = PH_KEYBODY;
                                            fc_next    = acc_shift;
                                        end
                                    end
                                    default: begin
                                        if (acc_shift == '0) begin
                                            if (depth_reg != '0)
                                                depth_next = depth_reg - DW'(1);
                                            end_step   = 1'b0;
                                            state_next = S_RD;
                                        end else begin
                                            if (depth_reg != '0) begin
                                                mem_we    = 1'b1;
                                                mem_waddr = depth_reg[AW-1:0] - AW'(1);
                                                mem_wdata = {1'b1, acc_shift};
                                            end
                                            phase_next = PH_MARKER;
                                        end
                                    end
                                endcase
                            end
                        end
                        PH_OBJEND: begin
                            if (b != MK_OBJ_END) begin
                                st_valid = 1'b1;
                                st_code  = ST_BAD_END;
                            end else begin
                                if (depth_reg != '0) depth_next = depth_reg - DW'(1);
                                end_step   = 1'b0;
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            phase_next = PH_MARKER;
                            fc_next    = '0;
                            acc_next   = '0;
                            depth_next = '0;
                        end
                    endcase
                end
            end
            S_RD: begin
                if (out_free) begin
                    if (depth_reg == '0) begin
                        phase_next = PH_MARKER;
                        st_valid   = 1'b1;
                        st_code    = ST_OK;
                        end_step   = 1'b1;
                    end else begin
                        mem_re     = 1'b1;
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    if (!rdata_reg[32]) begin
                        phase_next = PH_KEYLEN;
                        fc_next    = 32'd2;
                        acc_next   = '0;
                        end_step   = 1'b1;
                    end else if (cnt == '0) begin
                        depth_next = depth_reg - DW'(1);
                        state_next = S_RD;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = depth_reg[AW-1:0] - AW'(1);
                        mem_wdata  = {1'b1, cnt};
                        phase_next = PH_MARKER;
                        end_step   = 1'b1;
                    end
                end
            end
            default: state_next = S_ACCEPT;
        endcase

        // end of one byte's work: truncation check, result and recovery
        if (end_step) begin
            state_next = S_ACCEPT;
            if (!st_valid && step_last &&
                !(phase_next == PH_MARKER && depth_next == '0)) begin
                st_valid = 1'b1;
                st_code  = ST_TRUNC;
            end
            if (st_valid) begin
                m_valid_next = 1'b1;
                m_data_next  = {5'd0, total_next, top_marker_next, st_code};
            end
            if ((st_valid && st_code != ST_OK) || step_last) begin
                phase_next = PH_MARKER;
                fc_next    = '0;
                acc_next   = '0;
                depth_next = '0;
            end
            if (st_valid && st_code != ST_OK)
                disc_next = (st_code != ST_TRUNC) && !step_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) frame_mem[mem_waddr] <= mem_wdata;
        if (mem_re) rdata_reg <= frame_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_ACCEPT;
            phase_reg      <= PH_MARKER;
            fc_reg         <= '0;
            acc_reg        <= '0;
            depth_reg      <= '0;
            top_marker_reg <= '0;
            total_reg      <= '0;
            disc_reg       <= 1'b0;
            last_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            fc_reg         <= fc_next;
            acc_reg        <= acc_next;
            depth_reg      <= depth_next;
            top_marker_reg <= top_marker_next;
            total_reg      <= total_next;
            disc_reg       <= disc_next;
            last_reg       <= last_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_MAX)
        else $error("frame stack depth beyond limit");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("stack read and write in one cycle");

    a_eval_has_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EVAL |-> depth_reg != '0)
        else $error("stack evaluated with no frame");

    a_disc_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        disc_reg |-> state_reg == S_ACCEPT && depth_reg == '0)
        else $error("discarding while a value is in progress");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg[2:0] <= ST_DEEP)
        else $error("result status out of range");
`endif

endmodule

`default_nettype wire

[dv/amf0_value_checker.sv]
// Result checker for the AMF0 value skip parser: follows the byte and result
// streams, predicts the outcome of every accepted byte and compares results.
// Depends on amf0_pkg for marker codes, status codes and stream widths.
module amf0_value_checker #(
    parameter int MAX_DEPTH = amf0_pkg::MAX_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [amf0_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [amf0_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             n_fail,
    output int                             n_pending
);
    import amf0_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef enum logic [3:0] {
        WANT_MARKER,
        IN_BODY,
        IN_STRLEN,
        IN_ECMA_HINT,
        IN_ARR_COUNT,
        IN_KEYLEN,
        IN_KEY,
        WANT_OBJ_END
    } parse_phase_t;

    typedef struct packed {
        logic [31:0] value_length;
        logic [7:0]  marker;
        logic [2:0]  status;
    } amf0_result_t;

    parse_phase_t ph;
    logic [31:0]  fcnt;
    logic [31:0]  acc;
    logic [32:0]  frames [MAX_DEPTH];   // [32] strict array, [31:0] elements left
    int           depth;
    logic [7:0]   top_mk;
    logic [31:0]  total;
    logic         dropping;
    amf0_result_t outcome_q[$];

    function automatic void go_idle();
        ph    = WANT_MARKER;
        fcnt  = '0;
        acc   = '0;
        depth = 0;
    endfunction

    // One value done; pops exhausted strict arrays. 1 when a top-level value ends.
    function automatic logic close_value();
        logic [31:0] left;
        logic        done;
        logic        top;
        done = 1'b0;
        top  = 1'b0;
        while (!done) begin
            if (depth == 0) begin
                ph   = WANT_MARKER;
                top  = 1'b1;
                done = 1'b1;
            end else if (!frames[depth-1][32]) begin
                // inside an object: next comes a key
                ph   = IN_KEYLEN;
                fcnt = 32'd2;
                acc  = '0;
                done = 1'b1;
            end else begin
                left = frames[depth-1][31:0] - 32'd1;
                if (left == 32'd0) begin
                    depth = depth - 1;
                end else begin
                    frames[depth-1] = {1'b1, left};
                    ph   = WANT_MARKER;
                    done = 1'b1;
                end
            end
        end
        return top;
    endfunction

    // Advances the parse by one byte; 1 when the byte itself ends in a result.
    function automatic logic parse_byte(input logic [7:0] b, output logic [2:0] st);
        st = ST_OK;
        case (ph)
            WANT_MARKER: begin
                case (b)
                    MK_NUMBER:   begin ph = IN_BODY; fcnt = 32'd8; end
                    MK_BOOLEAN:  begin ph = IN_BODY; fcnt = 32'd1; end
                    MK_DATE:     begin ph = IN_BODY; fcnt = DATE_BYTES; end
                    MK_STRING:   begin ph = IN_STRLEN; fcnt = 32'd2; acc = '0; end
                    MK_LONG_STR: begin ph = IN_STRLEN; fcnt = 32'd4; acc = '0; end
                    MK_NULL, MK_UNDEF: return close_value();
                    MK_OBJECT, MK_ECMA, MK_STRICT: begin
                        if (depth >= MAX_DEPTH) begin
                            st = ST_DEEP;
                            return 1'b1;
                        end
                        frames[depth] = {b == MK_STRICT, 32'd0};
                        depth = depth + 1;
                        acc   = '0;
                        if (b == MK_OBJECT) begin
                            ph   = IN_KEYLEN;
                            fcnt = 32'd2;
                        end else if (b == MK_ECMA) begin
                            ph   = IN_ECMA_HINT;
                            fcnt = 32'd4;
                        end else begin
                            ph   = IN_ARR_COUNT;
                            fcnt = 32'd4;
                        end
                    end
                    default: begin
                        st = ST_BAD_MK;
                        return 1'b1;
                    end
                endcase
                return 1'b0;
            end
            IN_BODY: begin
                fcnt = fcnt - 32'd1;
                if (fcnt == 32'd0) return close_value();
                return 1'b0;
            end
            IN_KEY: begin
                fcnt = fcnt - 32'd1;
                if (fcnt == 32'd0) ph = WANT_MARKER;
                return 1'b0;
            end
            IN_ECMA_HINT: begin
                // count hint is skipped, pairs follow
                fcnt = fcnt - 32'd1;
                if (fcnt == 32'd0) begin
                    ph   = IN_KEYLEN;
                    fcnt = 32'd2;
                    acc  = '0;
                end
                return 1'b0;
            end
            IN_STRLEN, IN_ARR_COUNT, IN_KEYLEN: begin
                acc  = {acc[23:0], b};
                fcnt = fcnt - 32'd1;
                if (fcnt != 32'd0) return 1'b0;
                if (ph == IN_STRLEN) begin
                    if (acc == 32'd0) return close_value();
                    ph   = IN_BODY;
                    fcnt = acc;
                    return 1'b0;
                end
                if (ph == IN_KEYLEN) begin
                    if (acc == 32'd0) begin
                        ph = WANT_OBJ_END;
                    end else begin
                        ph   = IN_KEY;
                        fcnt = acc;
                    end
                    return 1'b0;
                end
                // empty strict array completes on its last count byte
                if (acc == 32'd0) begin
                    if (depth > 0) depth = depth - 1;
                    return close_value();
                end
                if (depth > 0) frames[depth-1] = {1'b1, acc};
                ph = WANT_MARKER;
                return 1'b0;
            end
            WANT_OBJ_END: begin
                if (b != MK_OBJ_END) begin
                    st = ST_BAD_END;
                    return 1'b1;
                end
                if (depth > 0) depth = depth - 1;
                return close_value();
            end
            default: begin
                go_idle();
                return 1'b0;
            end
        endcase
    endfunction

    task automatic take_request(input logic [7:0] b, input logic fin);
        logic [2:0]   st;
        logic         hit;
        amf0_result_t r;
        // after an error everything up to the end of the buffer is dropped
        if (dropping) begin
            if (fin) begin
                dropping = 1'b0;
                go_idle();
            end
            return;
        end
        if (ph == WANT_MARKER && depth == 0) begin
            top_mk = b;
            total  = '0;
        end
        if (total != '1) total = total + 32'd1;
        hit = parse_byte(b, st);
        if (!hit) begin
            if (!fin || (ph == WANT_MARKER && depth == 0)) return;
            st = ST_TRUNC;
        end
        r.status       = st;
        r.marker       = top_mk;
        r.value_length = total;
        outcome_q      = {outcome_q, r};
        if (st != ST_OK) begin
            go_idle();
            dropping = (st != ST_TRUNC) && !fin;
        end else if (fin) begin
            go_idle();
        end
    endtask

    always @(posedge aclk) begin
        amf0_result_t got;
        amf0_result_t want;
        if (!aresetn) begin
            go_idle();
            foreach (frames[i]) frames[i] = '0;
            top_mk   = '0;
            total    = '0;
            dropping = 1'b0;
            outcome_q.delete();
            n_fail   = 0;
        end else begin
            if (s_tvalid && s_tready) take_request(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(amf0_result_t)-1:0];
                if (outcome_q.size() == 0) begin
                    if (n_fail < REPORT_MAX)
                        $display("unexpected result: status %0d marker %h length %0d",
                                 got.status, got.marker, got.value_length);
                    n_fail = n_fail + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status != want.status || got.marker != want.marker ||
                        got.value_length != want.value_length) begin
                        if (n_fail < REPORT_MAX)
                            $display("mismatch: status %0d/%0d marker %h/%h length %0d/%0d",
                                     want.status, got.status, want.marker, got.marker,
                                     want.value_length, got.value_length);
                        n_fail = n_fail + 1;
                    end
                end
            end
        end
        n_pending = outcome_q.size();
    end

endmodule

[dv/tb_amf0_value_skip_parser_top.sv]
// Testbench top for the AMF0 value skip parser: builds byte buffers, drives
// both streams and gives the verdict. Depends on amf0_pkg, the block and
// amf0_value_checker, which predicts and compares every result.
module tb_amf0_value_skip_parser_top;
    import amf0_pkg::*;

    localparam int DEPTH_LIMIT   = MAX_DEPTH_DEF;
    // the limit is taken well above the slowest run, in which both sides
    // idle hard and cascades pop
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 300;
    // covers the longest pop cascade, with margin
    localparam int SETTLE_CYCLES = 80;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int         n_fail;
    int         n_pending;
    int         send_idle = 0;      // percent of cycles the sender sits out
    int         stall_pct = 0;      // percent of cycles the receiver stalls
    bit         hold_kick = 1'b0;   // asks the receiver for a long hold-off
    int         hold_left = 0;
    int         cycle_cnt = 0;
    logic [7:0] msg_q[$];           // buffer being built, tlast on its final byte
    int         junk_n;             // trailing bytes the block will drop

    amf0_value_skip_parser_top #(
        .MAX_DEPTH (DEPTH_LIMIT)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    amf0_value_checker #(
        .MAX_DEPTH (DEPTH_LIMIT)
    ) u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_fail    (n_fail),
        .n_pending (n_pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run guard
    always @(posedge aclk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_amf0_value_skip_parser_top: errors");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off on request so that the
    // block backs up and drops s_tready while the sender keeps offering.
    always @(posedge aclk) begin
        if (hold_kick) begin
            hold_kick = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic is_marker(input logic [7:0] v);
        case (v)
            MK_NUMBER, MK_BOOLEAN, MK_STRING, MK_OBJECT, MK_NULL, MK_UNDEF,
            MK_ECMA, MK_STRICT, MK_DATE, MK_LONG_STR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] pick_bad_marker();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        while (is_marker(v)) v = 8'($urandom_range(255));
        return v;
    endfunction

    function automatic logic [7:0] pick_bad_end();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        while (v == MK_OBJ_END) v = 8'($urandom_range(255));
        return v;
    endfunction

    function automatic logic [7:0] pick_container();
        case ($urandom_range(2))
            0:       return MK_OBJECT;
            1:       return MK_ECMA;
            default: return MK_STRICT;
        endcase
    endfunction

    // appends one byte to the buffer being built
    task automatic put_octet(input logic [7:0] v);
        msg_q = {msg_q, v};
    endtask

    // big-endian length or count field
    task automatic put_be(input int n, input logic [31:0] v);
        for (int i = n - 1; i >= 0; i--) put_octet(v[8*i +: 8]);
    endtask

    task automatic put_random(input int n);
        repeat (n) put_octet(8'($urandom_range(255)));
    endtask

    task automatic add_junk();
        junk_n = $urandom_range(4);
        put_random(junk_n);
    endtask

    // Well-formed value with random content; containers only below level 3.
    task automatic gen_value(input int lvl);
        int kind;
        int n;
        kind = (lvl >= 3) ? $urandom_range(5) : $urandom_range(8);
        case (kind)
            0: begin put_octet(MK_NUMBER); put_random(8); end
            1: begin put_octet(MK_BOOLEAN); put_random(1); end
            2: begin
                n = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                put_octet(MK_STRING);
                put_be(2, n);
                put_random(n);
            end
            3: begin
                n = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                put_octet(MK_LONG_STR);
                put_be(4, n);
                put_random(n);
            end
            4: put_octet($urandom_range(1) ? MK_NULL : MK_UNDEF);
            5: begin put_octet(MK_DATE); put_random(DATE_BYTES); end
            6: begin put_octet(MK_OBJECT); put_pairs(lvl); end
            7: begin put_octet(MK_ECMA); put_random(4); put_pairs(lvl); end
            default: begin
                n = $urandom_range(3);
                put_octet(MK_STRICT);
                put_be(4, n);
                repeat (n) gen_value(lvl + 1);
            end
        endcase
    endtask

    // key/value pairs closed by an empty key and the end marker
    task automatic put_pairs(input int lvl);
        int len;
        repeat ($urandom_range(2)) begin
            len = $urandom_range(1, 4);
            put_be(2, len);
            put_random(len);
            gen_value(lvl + 1);
        end
        put_be(2, 0);
        put_octet(MK_OBJ_END);
    endtask

    // Nest containers one inside the next. With overflow set, one more
    // container marker follows a full stack and the rest is dropped.
    task automatic build_deep(input int levels, input bit overflow);
        int kinds[$];
        int k;
        msg_q.delete();
        junk_n = 0;
        for (int i = 0; i < levels; i++) begin
            k = $urandom_range(2);
            kinds = {kinds, k};
            case (k)
                0: begin put_octet(MK_OBJECT); put_be(2, 1); put_random(1); end
                1: begin
                    put_octet(MK_ECMA);
                    put_random(4);
                    put_be(2, 1);
                    put_random(1);
                end
                default: begin put_octet(MK_STRICT); put_be(4, 1); end
            endcase
        end
        if (overflow) begin
            put_octet(pick_container());
            add_junk();
        end else begin
            gen_value(3);
            // closing strict arrays pop as a cascade, objects need their end
            for (int i = levels - 1; i >= 0; i--) begin
                if (kinds[i] != 2) begin
                    put_be(2, 0);
                    put_octet(MK_OBJ_END);
                end
            end
        end
    endtask

    task automatic build_msg();
        int r;
        int cut;
        int at;
        msg_q.delete();
        junk_n = 0;
        r = $urandom_range(99);
        if (r < 55) begin
            repeat ($urandom_range(1, 3)) gen_value(0);
        end else if (r < 63) begin
            // buffer cut at a random point, most often mid-value
            repeat ($urandom_range(1, 2)) gen_value(0);
            cut = $urandom_range(1, msg_q.size());
            while (msg_q.size() > cut) void'(msg_q.pop_back());
        end else if (r < 70) begin
            repeat ($urandom_range(2)) gen_value(0);
            put_octet(pick_bad_marker());
            add_junk();
        end else if (r < 76) begin
            // object or ECMA array whose empty key is not followed by 0x09
            if ($urandom_range(1)) begin
                put_octet(MK_OBJECT);
            end else begin
                put_octet(MK_ECMA);
                put_random(4);
            end
            if ($urandom_range(1)) begin
                put_be(2, 1);
                put_random(1);
                gen_value(2);
            end
            put_be(2, 0);
            put_octet(pick_bad_end());
            add_junk();
        end else if (r < 81) begin
            put_random($urandom_range(1, 6));
            junk_n = msg_q.size() - 1;
        end else if (r < 87) begin
            // random, mostly huge lengths and counts, cut short by tlast
            case ($urandom_range(2))
                0: begin
                    put_octet(MK_LONG_STR);
                    put_random(4);
                    put_random($urandom_range(3));
                end
                1: begin
                    put_octet(MK_STRING);
                    put_random(2);
                    put_random($urandom_range(3));
                end
                default: begin
                    put_octet(MK_STRICT);
                    put_random(4);
                    repeat ($urandom_range(2)) gen_value(2);
                end
            endcase
        end else if (r < 93) begin
            if ($urandom_range(2) == 0) build_deep(DEPTH_LIMIT, 1'b1);
            else build_deep($urandom_range(DEPTH_LIMIT - 3, DEPTH_LIMIT), 1'b0);
        end else begin
            repeat ($urandom_range(1, 2)) gen_value(0);
            at = $urandom_range(msg_q.size() - 1);
            msg_q[at] = 8'($urandom_range(255));
        end
    endtask

    // one byte request; idle cycles go before it with s_tvalid low
    task automatic send_octet(input logic [7:0] d, input logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_msg();
        foreach (msg_q[i]) send_octet(msg_q[i], i == msg_q.size() - 1);
    endtask

    // sender pauses until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int s_idle, input int r_stall, input int quota);
        int taken;
        taken     = 0;
        send_idle = s_idle;
        stall_pct = r_stall;
        while (taken < quota) begin
            build_msg();
            taken += msg_q.size() - junk_n;
            send_msg();
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // null, then undefined and a boolean in one buffer
        msg_q = '{MK_NULL};
        send_msg();
        msg_q = '{MK_UNDEF, MK_BOOLEAN, 8'hFF};
        send_msg();
        // empty string and empty strict array finish on their last length byte
        msg_q = '{MK_STRING, 8'h00, 8'h00};
        send_msg();
        msg_q = '{MK_STRICT, 8'h00, 8'h00, 8'h00, 8'h00};
        send_msg();
        // bad marker on the final byte: error, nothing to drop
        msg_q = '{8'hFF};
        send_msg();
        // bad object end, the rest of the buffer is dropped
        msg_q = '{MK_OBJECT, 8'h00, 8'h00, 8'h07, 8'h04, MK_NULL};
        send_msg();
        // buffer ends inside a length field
        msg_q = '{MK_LONG_STR, 8'hFF};
        send_msg();

        // stack exactly full, then one level too deep
        build_deep(DEPTH_LIMIT, 1'b0);
        send_msg();
        build_deep(DEPTH_LIMIT, 1'b1);
        send_msg();
        drain();

        // long receiver hold-off while bytes keep coming, no idling
        hold_kick = 1'b1;
        repeat (4) begin
            build_msg();
            send_msg();
        end
        drain();

        run_phase(0, 0, 200);
        run_phase(87, 0, 200);
        run_phase(0, 87, 200);
        run_phase(25, 25, 250);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("tb_amf0_value_skip_parser_top: clean");
        end else begin
            $display("tb_amf0_value_skip_parser_top: errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/amf0_pkg.sv
rtl/amf0_value_skip_parser_top.sv
dv/amf0_value_checker.sv
dv/tb_amf0_value_skip_parser_top.sv
